### rtl/core/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
// No dependencies; used by spq_front, spq_back and sorted_priority_queue.
package spq_pkg;

  // Fixed field widths of the item and result words.
  localparam int ItemDataW = 32;
  localparam int PrioW     = 16;

  // Operation carried by an input word.
  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Classified request passed from the front queue to the slot array.
  typedef struct packed {
    op_t                       op;
    logic [ItemDataW-1:0]      data;
    logic signed [PrioW-1:0]   prio;
  } req_t;

endpackage

### rtl/core/spq_front.sv
// Front end of the sorted priority queue: accepts input words, decodes the
// operation and buffers requests in a two-entry queue. Depends on spq_pkg.
module spq_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_cmd,
  input  logic [spq_pkg::ItemDataW-1:0]      in_item_data,
  input  logic signed [spq_pkg::PrioW-1:0]   in_item_priority,
  output logic                               req_valid,
  output spq_pkg::req_t                      req,
  input  logic                               req_take
);

  localparam int FifoDepth = 2;
  localparam int PtrW      = $clog2(FifoDepth);
  localparam int CntW      = $clog2(FifoDepth + 1);

  spq_pkg::req_t   mem_r [FifoDepth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  spq_pkg::req_t   new_req;
  logic            push;
  logic            pop;

  // Decode the incoming word into a request.
  always_comb begin
    new_req.op   = in_cmd ? spq_pkg::OP_REMOVE : spq_pkg::OP_INSERT;
    new_req.data = in_item_data;
    new_req.prio = in_item_priority;
  end

  // Handshake on both sides of the queue.
  assign in_stall  = (count_r == CntW'(FifoDepth));
  assign push      = in_valid && !in_stall;
  assign req_valid = (count_r != '0);
  assign pop       = req_take && req_valid;
  assign req       = mem_r[rd_ptr_r];

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_nxt = push ? PtrW'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = pop ? PtrW'(rd_ptr_r + 1'b1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = CntW'(count_r + 1'b1);
    end else if (pop && !push) begin
      count_nxt = CntW'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage needs no reset; only entries below the count are read.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= new_req;
    end
  end

endmodule

### rtl/core/spq_back.sv
// Back end of the sorted priority queue: the sorted slot array with a
// compare in every slot, and the result register. Depends on spq_pkg.
module spq_back #(
  parameter int QUEUE_DEPTH = 16,
  parameter int DATA_WIDTH  = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               req_valid,
  input  spq_pkg::req_t                      req,
  output logic                               req_take,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [1:0]                         out_status,
  output logic [spq_pkg::ItemDataW-1:0]      out_head_data,
  output logic signed [spq_pkg::PrioW-1:0]   out_head_priority,
  output logic                               out_is_empty
);

  // Only the low bits of the payload are kept.
  localparam int SlotW = (DATA_WIDTH < spq_pkg::ItemDataW) ? DATA_WIDTH
                                                            : spq_pkg::ItemDataW;

  logic [SlotW-1:0]                data_r   [QUEUE_DEPTH];
  logic signed [spq_pkg::PrioW-1:0] prio_r  [QUEUE_DEPTH];
  logic [SlotW-1:0]                data_nxt [QUEUE_DEPTH];
  logic signed [spq_pkg::PrioW-1:0] prio_nxt[QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]          valid_r, valid_nxt;
  logic [QUEUE_DEPTH-1:0]          le;

  logic                            out_valid_r;
  spq_pkg::status_t                out_status_r;
  logic [spq_pkg::ItemDataW-1:0]   out_data_r;
  logic signed [spq_pkg::PrioW-1:0] out_prio_r;
  logic                            out_empty_r;

  logic                            is_full;
  logic                            is_empty_now;
  logic                            ins_ok;
  logic                            rem_ok;
  logic                            slot_we;
  logic [SlotW-1:0]                new_data;
  logic [spq_pkg::ItemDataW-1:0]   head_ext;
  spq_pkg::status_t                status_nxt;
  logic                            empty_nxt;

  // The slot array works whenever the result register is free or draining.
  assign req_take     = req_valid && (!out_valid_r || !out_stall);
  assign is_full      = valid_r[QUEUE_DEPTH-1];
  assign is_empty_now = !valid_r[0];
  assign ins_ok       = req_take && (req.op == spq_pkg::OP_INSERT) && !is_full;
  assign rem_ok       = req_take && (req.op == spq_pkg::OP_REMOVE) && !is_empty_now;
  assign slot_we      = ins_ok || rem_ok;
  assign new_data     = req.data[SlotW-1:0];

  // Each valid slot whose priority is at most the new one stays in front.
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      le[i] = valid_r[i] && (prio_r[i] <= req.prio);
    end
  end

  // Per-slot next value: keep, take the new entry, or shift one way.
  genvar g;
  for (g = 0; g < QUEUE_DEPTH; g++) begin : g_slot
    logic                             take_new;
    logic                             from_prev;
    logic [SlotW-1:0]                 prev_data, succ_data;
    logic signed [spq_pkg::PrioW-1:0] prev_prio, succ_prio;

    if (g == 0) begin : g_first
      assign take_new  = !le[0];
      assign from_prev = 1'b0;
      assign prev_data = data_r[0];
      assign prev_prio = prio_r[0];
    end else begin : g_rest
      assign take_new  = le[g-1] && !le[g];
      assign from_prev = !le[g-1];
      assign prev_data = data_r[g-1];
      assign prev_prio = prio_r[g-1];
    end

    if (g == QUEUE_DEPTH - 1) begin : g_last
      assign succ_data = data_r[g];
      assign succ_prio = prio_r[g];
    end else begin : g_inner
      assign succ_data = data_r[g+1];
      assign succ_prio = prio_r[g+1];
    end

    always_comb begin
      data_nxt[g] = data_r[g];
      prio_nxt[g] = prio_r[g];
      if (ins_ok) begin
        if (take_new) begin
          data_nxt[g] = new_data;
          prio_nxt[g] = req.prio;
        end else if (from_prev) begin
          data_nxt[g] = prev_data;
          prio_nxt[g] = prev_prio;
        end
      end else if (rem_ok) begin
        data_nxt[g] = succ_data;
        prio_nxt[g] = succ_prio;
      end
    end
  end

  // Slot contents carry no reset; the valid bits say which ones count.
  always_ff @(posedge clk) begin
    if (slot_we) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        data_r[i] <= data_nxt[i];
        prio_r[i] <= prio_nxt[i];
      end
    end
  end

  // Valid bits form a thermometer code: grow on insert, shrink on remove.
  always_comb begin
    valid_nxt = valid_r;
    if (ins_ok) begin
      valid_nxt = {valid_r[QUEUE_DEPTH-2:0], 1'b1};
    end else if (rem_ok) begin
      valid_nxt = {1'b0, valid_r[QUEUE_DEPTH-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Widen the head payload to the result field.
  always_comb begin
    head_ext              = '0;
    head_ext[SlotW-1:0]   = data_r[0];
  end

  // Result status and empty flag after this word.
  always_comb begin
    status_nxt = spq_pkg::ST_OK;
    empty_nxt  = 1'b0;
    if (req.op == spq_pkg::OP_INSERT) begin
      if (is_full) begin
        status_nxt = spq_pkg::ST_FULL;
      end
      empty_nxt = 1'b0;
    end else begin
      if (is_empty_now) begin
        status_nxt = spq_pkg::ST_EMPTY;
        empty_nxt  = 1'b1;
      end else begin
        empty_nxt  = !valid_r[1];
      end
    end
  end

  // Result register control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (req_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (req_take) begin
      out_status_r <= status_nxt;
      out_data_r   <= rem_ok ? head_ext : '0;
      out_prio_r   <= rem_ok ? prio_r[0] : '0;
      out_empty_r  <= empty_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_head_data     = out_data_r;
  assign out_head_priority = out_prio_r;
  assign out_is_empty      = out_empty_r;

endmodule

### rtl/core/sorted_priority_queue.sv
// Sorted priority queue: ascending priority, equal priorities leave in order.
// A word passes through the request buffer and then the result register, and
// result stalls hold it longer. Throughput: one word per cycle while the
// result side does not stall, set by the compare-and-shift of the slot array.
// Reset (rst_n low, synchronous) empties the queue, the request buffer and the
// result register; slot contents are not cleared.
module sorted_priority_queue #(
  parameter int QUEUE_DEPTH = 16,
  parameter int DATA_WIDTH  = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_cmd,
  input  logic [spq_pkg::ItemDataW-1:0]      in_item_data,
  input  logic signed [spq_pkg::PrioW-1:0]   in_item_priority,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [1:0]                         out_status,
  output logic [spq_pkg::ItemDataW-1:0]      out_head_data,
  output logic signed [spq_pkg::PrioW-1:0]   out_head_priority,
  output logic                               out_is_empty
);

  logic          req_valid;
  logic          req_take;
  spq_pkg::req_t req;

  // Input decode and request buffer.
  spq_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cmd           (in_cmd),
    .in_item_data     (in_item_data),
    .in_item_priority (in_item_priority),
    .req_valid        (req_valid),
    .req              (req),
    .req_take         (req_take)
  );

  // Sorted slot array and result register.
  spq_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .DATA_WIDTH  (DATA_WIDTH)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .req_valid         (req_valid),
    .req               (req),
    .req_take          (req_take),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_head_data     (out_head_data),
    .out_head_priority (out_head_priority),
    .out_is_empty      (out_is_empty)
  );

endmodule

### sim/spq_checker.sv
// Checker for the sorted priority queue: watches the input and result channels,
// predicts every result word from its own copy of the queue and compares them.
// Depends on spq_pkg for the operation and status codes and the field widths.
module spq_checker
  import spq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16,
  parameter int DATA_WIDTH  = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic                      in_cmd,
  input  logic [ItemDataW-1:0]      in_item_data,
  input  logic signed [PrioW-1:0]   in_item_priority,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic [1:0]                out_status,
  input  logic [ItemDataW-1:0]      out_head_data,
  input  logic signed [PrioW-1:0]   out_head_priority,
  input  logic                      out_is_empty,
  output int                        fail_count,
  output int                        open_words
);
  timeunit 1ns;
  timeprecision 1ps;

  // Only the low DATA_WIDTH bits of a payload are kept in a slot.
  localparam int KeptW = (DATA_WIDTH < ItemDataW) ? DATA_WIDTH : ItemDataW;
  localparam logic [ItemDataW-1:0] PayloadMask = {ItemDataW{1'b1}} >> (ItemDataW - KeptW);

  typedef struct {
    status_t                 status;
    logic [ItemDataW-1:0]    data;
    logic signed [PrioW-1:0] prio;
    logic                    empty;
  } head_result_t;

  // Our own copy of the queue, slot 0 is the head.
  logic [ItemDataW-1:0]    slot_data_copy [QUEUE_DEPTH];
  logic signed [PrioW-1:0] slot_prio_copy [QUEUE_DEPTH];
  int                      held_entries;

  // Result words still owed by the block, oldest first.
  head_result_t            results_due [$];

  initial begin
    fail_count = 0;
    open_words = 0;
  end

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  // Applies one insert or remove to the copy and returns the result it must cause.
  function automatic head_result_t apply_queue_op(op_t op, logic [ItemDataW-1:0] data,
                                                  logic signed [PrioW-1:0] prio);
    head_result_t res;
    int           pos;
    res.status = ST_OK;
    res.data   = '0;
    res.prio   = '0;
    if (op == OP_INSERT) begin
      if (held_entries >= QUEUE_DEPTH) begin
        res.status = ST_FULL;
      end else begin
        // A new entry goes behind every entry of equal or smaller priority.
        pos = 0;
        while (pos < held_entries && slot_prio_copy[pos] <= prio) pos++;
        for (int i = held_entries; i > pos; i--) begin
          slot_data_copy[i] = slot_data_copy[i-1];
          slot_prio_copy[i] = slot_prio_copy[i-1];
        end
        slot_data_copy[pos] = data & PayloadMask;
        slot_prio_copy[pos] = prio;
        held_entries++;
      end
    end else begin
      if (held_entries == 0) begin
        res.status = ST_EMPTY;
      end else begin
        res.data = slot_data_copy[0];
        res.prio = slot_prio_copy[0];
        for (int i = 1; i < held_entries; i++) begin
          slot_data_copy[i-1] = slot_data_copy[i];
          slot_prio_copy[i-1] = slot_prio_copy[i];
        end
        held_entries--;
      end
    end
    res.empty = (held_entries == 0);
    return res;
  endfunction

  // Compare each accepted result word first, then predict from the accepted input word.
  always @(posedge clk) begin : watch
    head_result_t want;
    if (!rst_n) begin
      results_due.delete();
      held_entries = 0;
      open_words <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          report_mismatch($sformatf("result word with none expected, status %0d data %0h",
                                    out_status, out_head_data));
        end else begin
          want = results_due.pop_front();
          if (out_status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", out_status, want.status));
          if (out_head_data !== want.data)
            report_mismatch($sformatf("head_data %0h, expected %0h", out_head_data, want.data));
          if (out_head_priority !== want.prio)
            report_mismatch($sformatf("head_priority %0d, expected %0d",
                                      out_head_priority, want.prio));
          if (out_is_empty !== want.empty)
            report_mismatch($sformatf("is_empty %0b, expected %0b", out_is_empty, want.empty));
        end
      end
      if (in_valid && !in_stall)
        results_due.push_back(apply_queue_op(op_t'(in_cmd), in_item_data, in_item_priority));
      open_words <= results_due.size();
    end
  end

endmodule

### sim/sorted_priority_queue_tb.sv
// Top of the sorted priority queue testbench: clock, reset, input words and
// result stalls, with the verdict. Depends on spq_pkg, spq_checker and the block.
module sorted_priority_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import spq_pkg::*;

  localparam int QDepth      = 16;
  localparam int DataWidth   = 32;
  localparam int RandomWords = 700;
  localparam int CalmTail    = 100;
  localparam int HoldLen     = 48;
  localparam int DrainCycles = 8;
  localparam int CycleLimit  = 200000;

  logic                    clk              = 1'b0;
  logic                    rst_n            = 1'b0;
  logic                    in_valid         = 1'b0;
  logic                    in_stall;
  logic                    in_cmd           = OP_INSERT;
  logic [ItemDataW-1:0]    in_item_data     = '0;
  logic signed [PrioW-1:0] in_item_priority = '0;
  logic                    out_valid;
  logic                    out_stall        = 1'b0;
  logic [1:0]              out_status;
  logic [ItemDataW-1:0]    out_head_data;
  logic signed [PrioW-1:0] out_head_priority;
  logic                    out_is_empty;

  int   fail_count;
  int   open_words;
  int   cycle_count      = 0;
  logic hold_req         = 1'b0;
  logic calm             = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  sorted_priority_queue #(
    .QUEUE_DEPTH(QDepth),
    .DATA_WIDTH (DataWidth)
  ) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cmd           (in_cmd),
    .in_item_data     (in_item_data),
    .in_item_priority (in_item_priority),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_head_data    (out_head_data),
    .out_head_priority(out_head_priority),
    .out_is_empty     (out_is_empty)
  );

  spq_checker #(
    .QUEUE_DEPTH(QDepth),
    .DATA_WIDTH (DataWidth)
  ) u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cmd           (in_cmd),
    .in_item_data     (in_item_data),
    .in_item_priority (in_item_priority),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_head_data    (out_head_data),
    .out_head_priority(out_head_priority),
    .out_is_empty     (out_is_empty),
    .fail_count       (fail_count),
    .open_words       (open_words)
  );

  // Result side: random stall bursts, one long hold-off on request, none when calm.
  int stall_left;
  int hold_count;
  bit hold_done;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
      hold_count = 0;
      hold_done  = 1'b0;
    end else if (hold_req && !hold_done) begin
      out_stall <= 1'b1;
      hold_count++;
      if (hold_count >= HoldLen) hold_done = 1'b1;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (!calm && $urandom_range(0, 99) < 8) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(1, 14) - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Holds one word on the input channel until it is taken.
  task automatic send_word(op_t op, logic [ItemDataW-1:0] data, logic signed [PrioW-1:0] prio);
    in_valid         <= 1'b1;
    in_cmd           <= op;
    in_item_data     <= data;
    in_item_priority <= prio;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic sender_gap(int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Lowers valid and waits until every owed result word has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (open_words != 0) @(posedge clk);
  endtask

  // Mostly small priorities so that ties are common, sometimes any value or an extreme.
  task automatic send_random_word(int insert_pct);
    op_t                     op;
    logic signed [PrioW-1:0] prio;
    int                      pick;
    op   = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_REMOVE;
    pick = $urandom_range(0, 9);
    if (pick == 0)
      prio = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
    else if (pick <= 3)
      prio = 16'($urandom);
    else
      prio = 16'($urandom_range(0, 6) - 3);
    send_word(op, $urandom, prio);
  endtask

  // Stimulus and verdict.
  initial begin
    int insert_pct;
    insert_pct = 50;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Remove from the empty queue right after reset.
    send_word(OP_REMOVE, 32'hffff_ffff, 16'h7fff);
    // Extremes of payload and priority, with ties on zero and on the lowest priority.
    send_word(OP_INSERT, 32'h0000_0000, 16'sd0);
    send_word(OP_INSERT, 32'hffff_ffff, 16'h7fff);
    send_word(OP_INSERT, 32'h0000_0001, 16'h8000);
    send_word(OP_INSERT, 32'h0000_0002, 16'sd0);
    send_word(OP_INSERT, 32'h0000_0003, -16'sd1);
    send_word(OP_INSERT, 32'haaaa_5555, 16'sd0);
    send_word(OP_INSERT, 32'h5555_aaaa, 16'h7fff);
    send_word(OP_INSERT, 32'h8000_0000, 16'h8000);
    // A run of equal priorities fills the queue; they must leave in arrival order.
    for (int k = 0; k < 8; k++) send_word(OP_INSERT, 32'h100 + k, 16'sd5);
    // Insert into the full queue is refused, even at the best priority.
    send_word(OP_INSERT, 32'hdead_beef, 16'h8000);
    repeat (6) send_word(OP_REMOVE, 32'h0, 16'sd0);
    wait_drained();

    // Long hold-off on the result side while words keep coming.
    hold_req <= 1'b1;
    repeat (30) send_random_word(70);
    wait_drained();

    // Random part, in segments that lean toward filling or emptying the queue.
    for (int n = 0; n < RandomWords; n++) begin
      if (n % 50 == 0) begin
        case ($urandom_range(0, 3))
          0:       insert_pct = 20;
          1:       insert_pct = 50;
          2:       insert_pct = 80;
          default: insert_pct = 95;
        endcase
      end
      if (n == RandomWords - CalmTail) calm <= 1'b1;
      if (n < RandomWords - CalmTail && $urandom_range(0, 99) < 10)
        sender_gap($urandom_range(1, 14));
      send_random_word(insert_pct);
      if (n == RandomWords / 2) wait_drained();
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

endmodule
